[hw/rtl/amr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_pkg
// Shared constants, payload types and unit request and response types for
// the adaptive migration matrix router.
// ----------------------------------------------------------------------------
package amr_pkg;

    localparam int MAX_ISLANDS        = 8;
    localparam int PROB_FRACTION_BITS = 16;
    localparam int COUNT_BITS         = 16;

    localparam int ISL_BITS  = $clog2(MAX_ISLANDS);
    localparam int ISLC_W    = $clog2(MAX_ISLANDS + 1);
    localparam int CELLS     = MAX_ISLANDS * MAX_ISLANDS;
    localparam int CELL_BITS = 2 * ISL_BITS;

    localparam int PROB_W   = PROB_FRACTION_BITS + 1;
    localparam int SUM_W    = 48;
    localparam int AVG_W    = 32;
    localparam int WGT_W    = 16;
    localparam int WSUM_W   = WGT_W + ISL_BITS;
    localparam int RSUM_W   = PROB_W + ISL_BITS;
    localparam int CUM_W    = PROB_W + ISL_BITS;

    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = PROB_W + 17;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int V_W      = MUL_P_W + 1;

    localparam int DIV_N_W  = SUM_W;
    localparam int DIV_D_W0 = (COUNT_BITS > WSUM_W) ? COUNT_BITS : WSUM_W;
    localparam int DIV_D_W  = (DIV_D_W0 > RSUM_W) ? DIV_D_W0 : RSUM_W;
    localparam int DIV_C_W  = $clog2(DIV_N_W);

    localparam int DRAW_SHL = (PROB_FRACTION_BITS >= 16) ? PROB_FRACTION_BITS - 16 : 0;
    localparam int DRAW_SHR = (PROB_FRACTION_BITS >= 16) ? 0 : 16 - PROB_FRACTION_BITS;

    localparam logic [ISLC_W-1:0] NUM_ISLANDS_RESET = ISLC_W'(8);
    localparam logic [15:0]       ALPHA_RESET       = 16'd52429;
    localparam logic [15:0]       BETA_RESET        = 16'd655;

    localparam logic [2:0] CMD_RESET  = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_RECORD = 3'd2;
    localparam logic [2:0] CMD_LEARN  = 3'd3;
    localparam logic [2:0] CMD_LOAD   = 3'd4;
    localparam logic [2:0] CMD_UPDATE = 3'd5;
    localparam logic [2:0] CMD_SELECT = 3'd6;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SRC  = 2'd1;
    localparam logic [1:0] STAT_FALLBACK = 2'd2;

    localparam logic [1:0] REG_NUM_ISLANDS = 2'd0;
    localparam logic [1:0] REG_ALPHA       = 2'd1;
    localparam logic [1:0] REG_BETA        = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic [2:0]         island;
        logic [3:0]         source_island;
        logic signed [31:0] improvement;
        logic [2:0]         column;
        logic [15:0]        random_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] destination;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

[hw/rtl/amr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/amr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amr_div
    import amr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic               busy_reg;
    logic               done_reg;
    logic [DIV_C_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_C_W'(DIV_N_W - 1);
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                quo_reg  <= req.dividend;
            end else if (busy_reg) begin
                rem_reg <= fits ? DIV_D_W'(trial - {1'b0, dvs_reg}) : trial[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

[hw/rtl/amr_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module amr_mul
    import amr_pkg::*;
(
    input  logic               aclk,
    input  mul_req_t           req,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/adaptive_migration_matrix_router.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_migration_matrix_router
// Migration probability matrix with feedback learning, row update and
// roulette-wheel destination select.
// ----------------------------------------------------------------------------
// One command is worked at a time; s_ready is high only while the sequencer
// is idle, and one result transfer follows every command. Reset, clear,
// load and unused commands go straight to the result state, record reads
// and then writes its cell, and select walks the row column by column until
// the running sum reaches the draw or the row ends. Learn runs the shared
// divider once per cell with a nonzero count over the n by n area. A row
// update makes the max and tie passes, then per column a divider pass for
// the exploration weight if the weight sum is nonzero and the blend through
// the shared multiplier, then per column a divider pass to renormalize if
// the row sum is nonzero. Matrix, averages, sums and counts live in RAMs
// with per-entry valid bits, so reset and clear only clear the valid bits.
// ----------------------------------------------------------------------------
module adaptive_migration_matrix_router
    import amr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_payload,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [24:0] {
        S_IDLE    = 25'h0000001,
        S_REC_RD  = 25'h0000002,
        S_REC_WR  = 25'h0000004,
        S_LRN_RD  = 25'h0000008,
        S_LRN_CHK = 25'h0000010,
        S_LRN_DIV = 25'h0000020,
        S_MAX_RD  = 25'h0000040,
        S_MAX     = 25'h0000080,
        S_TIE_RD  = 25'h0000100,
        S_TIE     = 25'h0000200,
        S_Y       = 25'h0000400,
        S_YDIV    = 25'h0000800,
        S_UPM_RD  = 25'h0001000,
        S_UPM1    = 25'h0002000,
        S_UPM2    = 25'h0004000,
        S_UPM3    = 25'h0008000,
        S_UPM4    = 25'h0010000,
        S_UPM5    = 25'h0020000,
        S_UPM6    = 25'h0040000,
        S_NRM_RD  = 25'h0080000,
        S_NRM     = 25'h0100000,
        S_NDIV    = 25'h0200000,
        S_SEL_RD  = 25'h0400000,
        S_SEL     = 25'h0800000,
        S_DONE    = 25'h1000000
    } state_t;

    state_t state_reg;

    logic [ISLC_W-1:0]        num_islands_reg;
    logic [15:0]              alpha_reg;
    logic [15:0]              beta_reg;
    in_item_t                 item_reg;
    logic [ISL_BITS-1:0]      i_reg;
    logic [ISL_BITS-1:0]      j_reg;
    logic signed [AVG_W-1:0]  best_reg;
    logic [MAX_ISLANDS-1:0]   tie_reg;
    logic [WSUM_W-1:0]        wsum_reg;
    logic [PROB_W-1:0]        y_reg;
    logic [V_W-1:0]           acc_reg;
    logic [RSUM_W-1:0]        rsum_reg;
    logic [CUM_W-1:0]         cum_reg;
    logic [PROB_W-1:0]        uni_reg;
    logic                     sign_reg;
    logic [CELLS-1:0]         prob_vld_reg;
    logic [CELLS-1:0]         avg_vld_reg;
    logic [CELLS-1:0]         fb_vld_reg;
    logic                     pv_q_reg;
    logic                     av_q_reg;
    logic                     fv_q_reg;
    logic [WGT_W-1:0]         w_reg [MAX_ISLANDS];
    logic [2:0]               res_dest_reg;
    logic [1:0]               res_status_reg;
    logic                     m_valid_reg;
    out_item_t                m_payload_reg;

    logic [PROB_W-1:0] recip_tab [MAX_ISLANDS+1];

    for (genvar K = 0; K <= MAX_ISLANDS; K++) begin : g_recip
        localparam logic [PROB_W-1:0] RECIP_K =
            (K == 0) ? '0 : PROB_W'((64'd1 << PROB_FRACTION_BITS) / (K == 0 ? 1 : K));
        assign recip_tab[K] = RECIP_K;
    end

    logic [ISLC_W-1:0]    n_eff;
    logic [ISL_BITS-1:0]  rd_row;
    logic [ISL_BITS-1:0]  rd_col;
    logic [CELL_BITS-1:0] cell_addr;
    logic                 j_last;
    logic                 i_last;

    logic [PROB_W-1:0]  prob_rdata;
    logic [AVG_W-1:0]   avg_rdata;
    logic [SUM_W-1:0]   sum_rdata;
    logic [COUNT_BITS-1:0] cnt_rdata;

    logic                  prob_we;
    logic [PROB_W-1:0]     prob_wdata;
    logic                  avg_we;
    logic [AVG_W-1:0]      avg_wdata;
    logic                  fb_we;
    logic [SUM_W-1:0]      sum_wdata;
    logic [COUNT_BITS-1:0] cnt_wdata;

    logic [PROB_W-1:0]       prob_q;
    logic signed [AVG_W-1:0] avg_q;
    logic [SUM_W-1:0]        sum_q;
    logic [COUNT_BITS-1:0]   cnt_q;
    logic [PROB_W-1:0]       reward;
    logic [PROB_W-1:0]       r_j;
    logic [PROB_W-1:0]       y_uni;
    logic [MUL_A_W-1:0]      alpha_c;
    logic [MUL_A_W-1:0]      beta_c;
    logic [CUM_W-1:0]        cum_n;
    logic [CUM_W-1:0]        draw;
    logic [V_W-1:0]          v_sum;
    logic [PROB_W-1:0]       m_new;
    logic [SUM_W:0]          rec_sum;
    logic [SUM_W-1:0]        sum_mag;
    logic [AVG_W-1:0]        lrn_avg;
    logic                    in_bad_rec;
    logic                    in_row_ok;
    state_t                  accept_state;
    logic [2:0]              accept_dest;
    logic [1:0]              accept_status;

    mul_req_t           mul_req;
    logic [MUL_P_W-1:0] mul_prod;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    amr_ram #(.WIDTH(PROB_W), .DEPTH(CELLS)) u_prob_ram (
        .aclk(aclk), .we(prob_we), .waddr(cell_addr), .wdata(prob_wdata),
        .raddr(cell_addr), .rdata(prob_rdata)
    );

    amr_ram #(.WIDTH(AVG_W), .DEPTH(CELLS)) u_avg_ram (
        .aclk(aclk), .we(avg_we), .waddr(cell_addr), .wdata(avg_wdata),
        .raddr(cell_addr), .rdata(avg_rdata)
    );

    amr_ram #(.WIDTH(SUM_W), .DEPTH(CELLS)) u_sum_ram (
        .aclk(aclk), .we(fb_we), .waddr(cell_addr), .wdata(sum_wdata),
        .raddr(cell_addr), .rdata(sum_rdata)
    );

    amr_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_cnt_ram (
        .aclk(aclk), .we(fb_we), .waddr(cell_addr), .wdata(cnt_wdata),
        .raddr(cell_addr), .rdata(cnt_rdata)
    );

    amr_mul u_mul (.aclk(aclk), .req(mul_req), .prod(mul_prod));

    amr_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    always_comb begin
        if (num_islands_reg < ISLC_W'(2)) begin
            n_eff = ISLC_W'(2);
        end else if (num_islands_reg > ISLC_W'(MAX_ISLANDS)) begin
            n_eff = ISLC_W'(MAX_ISLANDS);
        end else begin
            n_eff = num_islands_reg;
        end
    end

    assign in_bad_rec = (s_payload.source_island >= 4'(n_eff))
                     || (ISLC_W'(s_payload.island) >= n_eff);
    assign in_row_ok  = ISLC_W'(s_payload.island) < n_eff;

    always_comb begin
        accept_state  = S_DONE;
        accept_dest   = '0;
        accept_status = STAT_OK;
        unique case (s_payload.command)
            CMD_RECORD: begin
                if (in_bad_rec) begin
                    accept_status = STAT_BAD_SRC;
                end else begin
                    accept_state = S_REC_RD;
                end
            end
            CMD_LEARN: begin
                accept_state = S_LRN_RD;
            end
            CMD_UPDATE: begin
                if (in_row_ok) begin
                    accept_state = S_MAX_RD;
                end
            end
            CMD_SELECT: begin
                if (in_row_ok) begin
                    accept_state = S_SEL_RD;
                end else begin
                    accept_dest   = 3'(n_eff - 1'b1);
                    accept_status = STAT_FALLBACK;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        rd_row = item_reg.island;
        rd_col = j_reg;
        if (state_reg == S_LRN_RD || state_reg == S_LRN_CHK || state_reg == S_LRN_DIV) begin
            rd_row = i_reg;
        end else if (state_reg == S_REC_RD || state_reg == S_REC_WR) begin
            rd_row = item_reg.source_island[ISL_BITS-1:0];
            rd_col = item_reg.island;
        end
    end

    assign cell_addr = {rd_row, rd_col};
    assign j_last    = (ISLC_W'(j_reg) + 1'b1) == n_eff;
    assign i_last    = (ISLC_W'(i_reg) + 1'b1) == n_eff;

    assign prob_q  = pv_q_reg ? prob_rdata : uni_reg;
    assign avg_q   = av_q_reg ? $signed(avg_rdata) : '0;
    assign sum_q   = fv_q_reg ? sum_rdata : '0;
    assign cnt_q   = fv_q_reg ? cnt_rdata : '0;
    assign reward  = recip_tab[ISLC_W'($countones(tie_reg))];
    assign r_j     = tie_reg[j_reg] ? reward : '0;
    assign y_uni   = recip_tab[n_eff];
    assign alpha_c = 17'h10000 - {1'b0, alpha_reg};
    assign beta_c  = 17'h10000 - {1'b0, beta_reg};
    assign cum_n   = cum_reg + CUM_W'(prob_q);
    assign draw    = (CUM_W'(item_reg.random_value) << DRAW_SHL) >> DRAW_SHR;
    assign v_sum   = acc_reg + (V_W'(mul_prod) << 16);
    assign m_new   = v_sum[32 +: PROB_W];

    assign rec_sum = {sum_q[SUM_W-1], sum_q}
                   + {{(SUM_W-31){item_reg.improvement[31]}}, item_reg.improvement};
    assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(~sum_q + 1'b1) : sum_q;

    always_comb begin
        if (!sign_reg) begin
            lrn_avg = (div_rsp.quot > DIV_N_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                               : div_rsp.quot[31:0];
        end else begin
            lrn_avg = (div_rsp.quot > DIV_N_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                                      : ~div_rsp.quot[31:0] + 1'b1;
        end
    end

    always_comb begin
        prob_we    = 1'b0;
        prob_wdata = m_new;
        avg_we     = 1'b0;
        avg_wdata  = lrn_avg;
        fb_we      = 1'b0;
        if (rec_sum[SUM_W] != rec_sum[SUM_W-1]) begin
            sum_wdata = rec_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_wdata = rec_sum[SUM_W-1:0];
        end
        cnt_wdata = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
        mul_req   = '0;
        div_req   = '0;
        unique case (state_reg)
            S_REC_WR: begin
                fb_we = 1'b1;
            end
            S_LRN_CHK: begin
                div_req.start    = cnt_q != '0;
                div_req.dividend = sum_mag;
                div_req.divisor  = DIV_D_W'(cnt_q);
            end
            S_LRN_DIV: begin
                avg_we = div_rsp.done;
            end
            S_Y: begin
                div_req.start    = wsum_reg != '0;
                div_req.dividend = DIV_N_W'({w_reg[j_reg], {PROB_FRACTION_BITS{1'b0}}});
                div_req.divisor  = DIV_D_W'(wsum_reg);
            end
            S_UPM1: begin
                mul_req.a = {1'b0, alpha_reg};
                mul_req.b = MUL_B_W'(prob_q);
            end
            S_UPM2: begin
                mul_req.a = alpha_c;
                mul_req.b = MUL_B_W'(r_j);
            end
            S_UPM4: begin
                mul_req.a = beta_c;
                mul_req.b = acc_reg[MUL_B_W-1:0];
            end
            S_UPM5: begin
                mul_req.a = {1'b0, beta_reg};
                mul_req.b = MUL_B_W'(y_reg);
            end
            S_UPM6: begin
                prob_we = 1'b1;
            end
            S_NRM: begin
                div_req.start    = rsum_reg != '0;
                div_req.dividend = DIV_N_W'({prob_q, {PROB_FRACTION_BITS{1'b0}}});
                div_req.divisor  = DIV_D_W'(rsum_reg);
                prob_we          = rsum_reg == '0;
                prob_wdata       = y_uni;
            end
            S_NDIV: begin
                prob_we    = div_rsp.done;
                prob_wdata = div_rsp.quot[PROB_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            num_islands_reg <= NUM_ISLANDS_RESET;
            alpha_reg       <= ALPHA_RESET;
            beta_reg        <= BETA_RESET;
            prob_vld_reg    <= '0;
            avg_vld_reg     <= '0;
            fb_vld_reg      <= '0;
            uni_reg         <= recip_tab[NUM_ISLANDS_RESET];
            m_valid_reg     <= 1'b0;
            for (int k = 0; k < MAX_ISLANDS; k++) begin
                w_reg[k] <= '0;
            end
        end else begin
            pv_q_reg <= prob_vld_reg[cell_addr];
            av_q_reg <= avg_vld_reg[cell_addr];
            fv_q_reg <= fb_vld_reg[cell_addr];
            if (prob_we) begin
                prob_vld_reg[cell_addr] <= 1'b1;
            end
            if (avg_we) begin
                avg_vld_reg[cell_addr] <= 1'b1;
            end
            if (fb_we) begin
                fb_vld_reg[cell_addr] <= 1'b1;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_NUM_ISLANDS: num_islands_reg <= cfg_wdata[ISLC_W-1:0];
                    REG_ALPHA:       alpha_reg <= cfg_wdata;
                    REG_BETA:        beta_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg       <= s_payload;
                        i_reg          <= '0;
                        j_reg          <= '0;
                        rsum_reg       <= '0;
                        cum_reg        <= '0;
                        tie_reg        <= '0;
                        res_dest_reg   <= accept_dest;
                        res_status_reg <= accept_status;
                        state_reg      <= accept_state;
                        unique case (s_payload.command)
                            CMD_RESET: begin
                                prob_vld_reg <= '0;
                                avg_vld_reg  <= '0;
                                fb_vld_reg   <= '0;
                                uni_reg      <= recip_tab[n_eff];
                            end
                            CMD_CLEAR: begin
                                fb_vld_reg <= '0;
                            end
                            CMD_LOAD: begin
                                if (int'(s_payload.column) < MAX_ISLANDS) begin
                                    w_reg[s_payload.column[ISL_BITS-1:0]] <= s_payload.random_value;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_REC_RD: state_reg <= S_REC_WR;
                S_REC_WR: state_reg <= S_DONE;
                S_LRN_RD: state_reg <= S_LRN_CHK;
                S_LRN_CHK, S_LRN_DIV: begin
                    if (state_reg == S_LRN_CHK && cnt_q != '0) begin
                        sign_reg  <= sum_q[SUM_W-1];
                        state_reg <= S_LRN_DIV;
                    end else if (state_reg == S_LRN_CHK || div_rsp.done) begin
                        if (j_last) begin
                            j_reg <= '0;
                            if (i_last) begin
                                state_reg <= S_DONE;
                            end else begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= S_LRN_RD;
                            end
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_LRN_RD;
                        end
                    end
                end
                S_MAX_RD: state_reg <= S_MAX;
                S_MAX: begin
                    if (j_reg == '0 || avg_q > best_reg) begin
                        best_reg <= avg_q;
                    end
                    wsum_reg <= ((j_reg == '0) ? '0 : wsum_reg) + WSUM_W'(w_reg[j_reg]);
                    if (j_last) begin
                        j_reg     <= '0;
                        state_reg <= S_TIE_RD;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_MAX_RD;
                    end
                end
                S_TIE_RD: state_reg <= S_TIE;
                S_TIE: begin
                    tie_reg[j_reg] <= avg_q == best_reg;
                    if (j_last) begin
                        j_reg     <= '0;
                        state_reg <= S_Y;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_TIE_RD;
                    end
                end
                S_Y: begin
                    if (wsum_reg != '0) begin
                        state_reg <= S_YDIV;
                    end else begin
                        y_reg     <= y_uni;
                        state_reg <= S_UPM_RD;
                    end
                end
                S_YDIV: begin
                    if (div_rsp.done) begin
                        y_reg     <= div_rsp.quot[PROB_W-1:0];
                        state_reg <= S_UPM_RD;
                    end
                end
                S_UPM_RD: state_reg <= S_UPM1;
                S_UPM1:   state_reg <= S_UPM2;
                S_UPM2: begin
                    acc_reg   <= V_W'(mul_prod);
                    state_reg <= S_UPM3;
                end
                S_UPM3: begin
                    acc_reg   <= acc_reg + V_W'(mul_prod);
                    state_reg <= S_UPM4;
                end
                S_UPM4: state_reg <= S_UPM5;
                S_UPM5: begin
                    acc_reg   <= V_W'(mul_prod);
                    state_reg <= S_UPM6;
                end
                S_UPM6: begin
                    rsum_reg <= rsum_reg + RSUM_W'(m_new);
                    if (j_last) begin
                        j_reg     <= '0;
                        state_reg <= S_NRM_RD;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_Y;
                    end
                end
                S_NRM_RD: state_reg <= S_NRM;
                S_NRM, S_NDIV: begin
                    if (state_reg == S_NRM && rsum_reg != '0) begin
                        state_reg <= S_NDIV;
                    end else if (state_reg == S_NRM || div_rsp.done) begin
                        if (j_last) begin
                            state_reg <= S_DONE;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_NRM_RD;
                        end
                    end
                end
                S_SEL_RD: state_reg <= S_SEL;
                S_SEL: begin
                    cum_reg <= cum_n;
                    if (draw <= cum_n) begin
                        res_dest_reg <= 3'(j_reg);
                        state_reg    <= S_DONE;
                    end else if (j_last) begin
                        res_dest_reg   <= 3'(n_eff - 1'b1);
                        res_status_reg <= STAT_FALLBACK;
                        state_reg      <= S_DONE;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SEL_RD;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_payload_reg.destination <= res_dest_reg;
                        m_payload_reg.status      <= res_status_reg;
                        state_reg                 <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = state_reg == S_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a command is in progress");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_bad_src_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == STAT_BAD_SRC) |-> (m_payload.destination == 3'd0))
        else $error("ignored record carries a destination");

endmodule

[test/amr_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amr_scoreboard
// Watches the command, result and register-write ports of the migration
// matrix router, keeps its own copy of the matrix and feedback state, works
// out the result of every accepted command and compares it, field by field,
// with the result transfers in order.
// ----------------------------------------------------------------------------
module amr_scoreboard
    import amr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_payload,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_payload,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          pending,
    output int          failures
);

    localparam longint unsigned ONE      = 64'd1 << PROB_FRACTION_BITS;
    localparam longint unsigned PMASK    = (64'd1 << (PROB_FRACTION_BITS + 1)) - 1;
    localparam longint unsigned CNT_MAX  = (64'd1 << COUNT_BITS) - 1;
    localparam longint          SUM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          SUM_LO   = -SUM_HI - 1;

    logic [3:0]  islands_reg;
    logic [15:0] alpha_reg;
    logic [15:0] beta_reg;

    longint unsigned prob_m [CELLS];
    longint          avg_m  [CELLS];
    longint          sum_m  [CELLS];
    longint unsigned cnt_m  [CELLS];
    longint unsigned wgt_m  [MAX_ISLANDS];

    out_item_t result_q[$];

    assign pending = result_q.size();

    function automatic int islands_in_use();
        int n;
        n = islands_reg;
        if (n < 2) n = 2;
        if (n > MAX_ISLANDS) n = MAX_ISLANDS;
        return n;
    endfunction

    function automatic void clear_matrix_state(bit with_matrix);
        for (int c = 0; c < CELLS; c++) begin
            if (with_matrix) begin
                prob_m[c] = ONE / islands_in_use();
                avg_m[c]  = 0;
            end
            sum_m[c] = 0;
            cnt_m[c] = 0;
        end
    endfunction

    function automatic void update_row(int row, int n);
        longint          best;
        int              ties;
        longint unsigned reward, wsum, rsum, r, inner, v;
        longint unsigned y [MAX_ISLANDS];
        best = avg_m[row * MAX_ISLANDS];
        ties = 0;
        wsum = 0;
        rsum = 0;
        for (int j = 1; j < n; j++)
            if (avg_m[row * MAX_ISLANDS + j] > best) best = avg_m[row * MAX_ISLANDS + j];
        for (int j = 0; j < n; j++)
            if (avg_m[row * MAX_ISLANDS + j] == best) ties++;
        reward = ONE / ties;
        for (int j = 0; j < n; j++) wsum += wgt_m[j];
        for (int j = 0; j < n; j++)
            y[j] = (wsum != 0) ? (wgt_m[j] * ONE) / wsum : ONE / n;
        for (int j = 0; j < n; j++) begin
            r     = (avg_m[row * MAX_ISLANDS + j] == best) ? reward : 0;
            inner = alpha_reg * prob_m[row * MAX_ISLANDS + j] + (65536 - alpha_reg) * r;
            v     = (65536 - beta_reg) * inner + beta_reg * 65536 * y[j];
            prob_m[row * MAX_ISLANDS + j] = (v >> 32) & PMASK;
            rsum += prob_m[row * MAX_ISLANDS + j];
        end
        for (int j = 0; j < n; j++)
            prob_m[row * MAX_ISLANDS + j] = (rsum != 0) ?
                ((prob_m[row * MAX_ISLANDS + j] * ONE) / rsum) & PMASK : ONE / n;
    endfunction

    function automatic out_item_t route_command(in_item_t it);
        out_item_t       res;
        int              n, c;
        longint          s, a;
        longint unsigned cum, draw;
        bit              found;
        n   = islands_in_use();
        res = '0;
        case (it.command)
            CMD_RESET: clear_matrix_state(1'b1);
            CMD_CLEAR: clear_matrix_state(1'b0);
            CMD_RECORD: begin
                if (it.source_island >= n || it.island >= n) begin
                    res.status = STAT_BAD_SRC;
                end else begin
                    c = it.source_island * MAX_ISLANDS + it.island;
                    s = sum_m[c] + longint'(it.improvement);
                    if (s > SUM_HI) s = SUM_HI;
                    if (s < SUM_LO) s = SUM_LO;
                    sum_m[c] = s;
                    if (cnt_m[c] < CNT_MAX) cnt_m[c]++;
                end
            end
            CMD_LEARN: begin
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++) begin
                        c = i * MAX_ISLANDS + j;
                        if (cnt_m[c] != 0) begin
                            a = sum_m[c] / longint'(cnt_m[c]);
                            if (a > 64'sd2147483647) a = 64'sd2147483647;
                            if (a < -64'sd2147483648) a = -64'sd2147483648;
                            avg_m[c] = a;
                        end
                    end
            end
            CMD_LOAD: if (it.column < MAX_ISLANDS) wgt_m[it.column] = it.random_value;
            CMD_UPDATE: if (it.island < n) update_row(it.island, n);
            CMD_SELECT: begin
                found = 1'b0;
                cum   = 0;
                draw  = longint'(it.random_value) << DRAW_SHL >> DRAW_SHR;
                if (it.island < n)
                    for (int j = 0; j < n && !found; j++) begin
                        cum += prob_m[it.island * MAX_ISLANDS + j];
                        if (draw <= cum) begin
                            res.destination = 3'(j);
                            found = 1'b1;
                        end
                    end
                if (!found) begin
                    res.destination = 3'(n - 1);
                    res.status      = STAT_FALLBACK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t exp_r;
        if (!aresetn) begin
            islands_reg = NUM_ISLANDS_RESET;
            alpha_reg   = ALPHA_RESET;
            beta_reg    = BETA_RESET;
            clear_matrix_state(1'b1);
            for (int j = 0; j < MAX_ISLANDS; j++) wgt_m[j] = 0;
            result_q.delete();
            failures = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NUM_ISLANDS: islands_reg = cfg_wdata[3:0];
                    REG_ALPHA:       alpha_reg   = cfg_wdata;
                    REG_BETA:        beta_reg    = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual dest %0d status %0d",
                             $time, m_payload.destination, m_payload.status);
                    failures++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (exp_r.destination !== m_payload.destination) begin
                        $display("%0t: destination expected %0d actual %0d",
                                 $time, exp_r.destination, m_payload.destination);
                        failures++;
                    end
                    if (exp_r.status !== m_payload.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, m_payload.status);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) result_q.insert(result_q.size(), route_command(s_payload));
        end
    end

endmodule

[test/adaptive_migration_matrix_router_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_migration_matrix_router_tb
// Drives directed and random command streams into the migration matrix
// router under several island counts and blend weights, with random gaps
// and result back-pressure; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module adaptive_migration_matrix_router_tb
    import amr_pkg::*;
;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_payload;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_payload;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    int          pending;
    int          failures;
    int          cur_islands;

    adaptive_migration_matrix_router dut (.*);

    amr_scoreboard scoreboard (
        .aclk, .aresetn, .s_valid, .s_ready, .s_payload, .m_valid, .m_ready,
        .m_payload, .cfg_wr_en, .cfg_index, .cfg_wdata, .pending, .failures
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic int gap_length();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    task automatic send_command(in_item_t it);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic in_item_t make_cmd(logic [2:0] cmd, int isl, int src,
                                          logic [31:0] imp, int col, int rnd);
        in_item_t it;
        it.command       = cmd;
        it.island        = 3'(isl);
        it.source_island = 4'(src);
        it.improvement   = imp;
        it.column        = 3'(col);
        it.random_value  = 16'(rnd);
        return it;
    endfunction

    function automatic in_item_t random_cmd();
        in_item_t it;
        int p, n;
        n = cur_islands;
        it.command       = CMD_RECORD;
        it.island        = 3'($urandom_range(n - 1));
        it.source_island = 4'($urandom_range(n - 1));
        it.improvement   = ($urandom_range(1)) ? $urandom : $urandom_range(2097152) - 1048576;
        it.column        = 3'($urandom_range(7));
        it.random_value  = 16'($urandom_range(65535));
        if ($urandom_range(9) == 0) it.island = 3'($urandom_range(7));
        if ($urandom_range(9) == 0) it.source_island = 4'($urandom_range(15));
        p = $urandom_range(99);
        if (p < 52)      it.command = CMD_RECORD;
        else if (p < 74) it.command = CMD_SELECT;
        else if (p < 81) it.command = CMD_LOAD;
        else if (p < 88) it.command = CMD_UPDATE;
        else if (p < 92) it.command = CMD_LEARN;
        else if (p < 94) it.command = CMD_CLEAR;
        else if (p < 96) it.command = CMD_RESET;
        else             it.command = CMD_UNUSED;
        return it;
    endfunction

    // receiver: randomly chosen stall modes plus one long hold-off
    initial begin
        int cyc, mode;
        cyc  = 0;
        mode = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 200 == 0) mode = $urandom_range(2);
            if (cyc >= 3000 && cyc < 3400) m_ready <= 1'b0;
            else if (mode == 0) m_ready <= 1'b1;
            else if (mode == 1) m_ready <= ($urandom_range(3) != 0);
            else m_ready <= ($urandom_range(39) != 0) ? 1'b1 : 1'b0;
        end
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int islands_set [7] = '{8, 2, 15, 0, 5, 1, 3};
        int alpha_set   [7] = '{52429, 1, 65535, 32768, 52429, 40000, 65535};
        int beta_set    [7] = '{655, 1, 65535, 100, 655, 3000, 1};
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_NUM_ISLANDS;
        cfg_wdata = '0;
        cur_islands = 8;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_command(make_cmd(CMD_SELECT, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_SELECT, 3, 0, 0, 0, 65535));
        send_command(make_cmd(CMD_LOAD, 0, 0, 0, 0, 65535));
        send_command(make_cmd(CMD_LOAD, 0, 0, 0, 7, 1));
        send_command(make_cmd(CMD_LOAD, 0, 0, 0, 3, 0));
        send_command(make_cmd(CMD_RECORD, 7, 0, 32'h7FFF_FFFF, 0, 0));
        send_command(make_cmd(CMD_RECORD, 7, 0, 32'h7FFF_FFFF, 0, 0));
        send_command(make_cmd(CMD_RECORD, 0, 7, 32'h8000_0000, 0, 0));
        send_command(make_cmd(CMD_RECORD, 1, 0, 32'hFFFF_FFFF, 0, 0));
        send_command(make_cmd(CMD_RECORD, 2, 15, 32'h0001_0000, 0, 0));
        send_command(make_cmd(CMD_RECORD, 2, 8, 32'h0001_0000, 0, 0));
        send_command(make_cmd(CMD_LEARN, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_UPDATE, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_UPDATE, 7, 0, 0, 0, 0));
        send_command(make_cmd(CMD_SELECT, 0, 0, 0, 0, 65535));
        send_command(make_cmd(CMD_SELECT, 7, 0, 0, 0, 30000));
        send_command(make_cmd(CMD_UNUSED, 5, 9, 32'h1234_5678, 6, 4321));
        send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_LEARN, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_RESET, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_SELECT, 1, 0, 0, 0, 8192));

        for (int ph = 0; ph < 7; ph++) begin
            quiesce();
            write_reg(REG_NUM_ISLANDS, 16'(islands_set[ph]));
            write_reg(REG_ALPHA, 16'(alpha_set[ph]));
            write_reg(REG_BETA, 16'(beta_set[ph]));
            cur_islands = (islands_set[ph] < 2) ? 2 :
                          (islands_set[ph] > MAX_ISLANDS) ? MAX_ISLANDS : islands_set[ph];
            if (ph == 2) begin
                send_command(make_cmd(CMD_SELECT, 7, 0, 0, 0, 0));
                send_command(make_cmd(CMD_RECORD, 7, 7, 32'h0000_0001, 0, 0));
            end
            for (int k = 0; k < 190; k++) send_command(random_cmd());
        end
        quiesce();
        repeat (50) @(posedge aclk);
        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/amr_pkg.sv
hw/rtl/amr_ram.sv
hw/rtl/amr_div.sv
hw/rtl/amr_mul.sv
hw/rtl/adaptive_migration_matrix_router.sv
test/amr_scoreboard.sv
test/adaptive_migration_matrix_router_tb.sv
